/* sv/chd_pkg.sv */
// package with shared constants and types of the canonical huffman decoder
`default_nettype none
package chd_pkg;
  localparam int NumSymbols = 256;
  localparam int MaxCodeLen = 32;
  localparam int SymW = 8;
  localparam int LenW = 6;
  localparam int CntW = 9;

  typedef enum logic [1:0] {
    ModeLoad  = 2'd0,
    ModeStart = 2'd1,
    ModeByte  = 2'd2,
    ModeEnd   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StSymbol  = 2'd0,
    StNoCode  = 2'd1,
    StNoBits  = 2'd2,
    StTooLong = 2'd3
  } status_e;
endpackage
`default_nettype wire

/* sv/chd_ram.sv */
// generic single port write, single port registered read ram
`default_nettype none
module chd_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* sv/canonical_huffman_decoder.sv */
// Canonical Huffman decoder: load lengths, build tables, decode bits serially.
// Load item: writes one code length. Start item: builds the tables with two sweeps over
// the length memory (tally, then placement) around one pass over the code lengths.
// Byte item: its bits step through SBit, each completed code takes a symbol read in SBitW
// and results leave via SOut, plus receiver stalls. End item: a StNoBits result in a run.
// Reset: asynchronous active low; a clearing pass zeroes all 256 length memory entries.
`default_nettype none
module canonical_huffman_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // symbol_index[7:0], code_length[15:8], expected_count[79:16], data_byte[87:80]
  input  wire logic [87:0] s_axis_tdata,
  // mode[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // symbol[7:0], stream_done[8]
  output logic [15:0]      m_axis_tdata,
  // status[1:0]
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);
  localparam int L = chd_pkg::MaxCodeLen;

  typedef enum logic [3:0] {
    SClear, SIdle, SCount, SCountW, SFirst, SPlace, SPlaceW, SBit, SBitW, SOut
  } state_e;

  typedef enum logic [1:0] {
    RunIdle   = 2'd0,
    RunActive = 2'd1,
    RunError  = 2'd2
  } run_e;

  state_e state_q;
  run_e run_q;
  logic [8:0] idx_q;
  logic [5:0] len_q;
  logic [7:0] byte_q;
  logic [3:0] bits_q;
  logic [63:0] rem_q;
  logic [31:0] pc_q, code_q;
  logic [chd_pkg::LenW-1:0] plen_q, longest_q;
  logic [8:0] fidx_q;
  logic too_long_q;
  // per length tables, entry n holds code length n+1
  logic [chd_pkg::CntW-1:0] cnt_q [L];
  logic [31:0] fc_q [L];
  logic [chd_pkg::CntW-1:0] fi_q [L];
  logic [chd_pkg::CntW-1:0] slot_q [L];
  logic [chd_pkg::SymW-1:0] res_sym_q;
  logic [1:0] res_st_q;
  logic res_done_q, res_last_q;
  // a decoded symbol waits here until it is known whether it ends the transaction
  logic held_q;

  // length memory
  logic       lw_we;
  logic [7:0] lw_addr, lw_data, lr_addr, lr_data;
  chd_ram #(.Width(8), .Depth(chd_pkg::NumSymbols)) u_len (
    .clk_i, .we_i(lw_we), .waddr_i(lw_addr), .wdata_i(lw_data),
    .raddr_i(lr_addr), .rdata_o(lr_data)
  );

  // sorted symbol memory
  logic       sw_we;
  logic [7:0] sw_addr, sr_addr, sr_data;
  chd_ram #(.Width(8), .Depth(chd_pkg::NumSymbols)) u_sym (
    .clk_i, .we_i(sw_we), .waddr_i(sw_addr), .wdata_i(idx_q[7:0]),
    .raddr_i(sr_addr), .rdata_o(sr_data)
  );

  logic acc;
  chd_pkg::mode_e mode;
  assign s_axis_tready = (state_q == SIdle) && !m_axis_tvalid;
  assign acc  = s_axis_tvalid && s_axis_tready;
  assign mode = chd_pkg::mode_e'(s_axis_tuser);

  // memory ports
  always_comb begin
    lw_we   = 1'b0;
    lw_addr = s_axis_tdata[7:0];
    lw_data = s_axis_tdata[15:8];
    if (state_q == SClear) begin
      lw_we = 1'b1;
      lw_addr = idx_q[7:0];
      lw_data = '0;
    end else if (acc && mode == chd_pkg::ModeLoad) begin
      lw_we = 1'b1;
    end
  end
  assign lr_addr = idx_q[7:0];

  // current bit step quantities
  logic [31:0] npc, diff;
  logic [5:0]  nlen;
  logic [4:0]  nslot;
  logic        bitv, hit;
  assign bitv  = byte_q[7];
  assign npc   = {pc_q[30:0], bitv};
  assign nlen  = plen_q + 6'd1;
  assign nslot = 5'(nlen - 6'd1);
  assign diff  = npc - fc_q[nslot];
  assign hit   = diff < 32'(cnt_q[nslot]);
  assign sr_addr = 8'(fi_q[nslot] + diff[8:0]);

  // length read back during the sweeps
  logic ok_len;
  logic [4:0] lslot;
  assign ok_len  = (lr_data != 8'd0) && (lr_data <= 8'(L));
  assign lslot   = 5'(lr_data[5:0] - 6'd1);
  assign sw_we   = (state_q == SPlaceW) && ok_len && (idx_q < 9'd256);
  assign sw_addr = 8'(slot_q[lslot]);

  // count of the next shorter length for the first code step
  logic [4:0] len_slot;
  logic [chd_pkg::CntW-1:0] cnt_prev;
  assign len_slot = 5'(len_q - 6'd1);
  assign cnt_prev = (len_q == 6'd1) ? '0 : cnt_q[5'(len_q - 6'd2)];

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      run_q <= RunIdle;
      idx_q <= '0;
      len_q <= '0;
      byte_q <= '0;
      bits_q <= '0;
      rem_q <= '0;
      pc_q <= '0;
      code_q <= '0;
      plen_q <= '0;
      fidx_q <= '0;
      too_long_q <= 1'b0;
      res_sym_q <= '0;
      res_st_q <= chd_pkg::StSymbol;
      res_done_q <= 1'b0;
      res_last_q <= 1'b0;
      held_q <= 1'b0;
      m_axis_tvalid <= 1'b0;
      longest_q <= '0;
      for (int i = 0; i < L; i++) begin
        cnt_q[i] <= '0;
        fc_q[i] <= '0;
        fi_q[i] <= '0;
        slot_q[i] <= '0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state_q)
        SClear: begin
          idx_q <= idx_q + 9'd1;
          if (idx_q == 9'd255) state_q <= SIdle;
        end
        SIdle: if (acc) begin
          case (mode)
            chd_pkg::ModeStart: begin
              for (int i = 0; i < L; i++) cnt_q[i] <= '0;
              longest_q <= '0;
              too_long_q <= 1'b0;
              rem_q <= s_axis_tdata[79:16];
              pc_q <= '0;
              plen_q <= '0;
              idx_q <= '0;
              state_q <= SCount;
            end
            chd_pkg::ModeByte: if (run_q == RunActive) begin
              byte_q <= s_axis_tdata[87:80];
              bits_q <= 4'd8;
              held_q <= 1'b0;
              state_q <= SBit;
            end
            chd_pkg::ModeEnd: if (run_q == RunActive) begin
              run_q <= RunError;
              res_sym_q <= '0; res_st_q <= chd_pkg::StNoBits;
              res_done_q <= 1'b0; res_last_q <= 1'b1;
              m_axis_tvalid <= 1'b1;
            end
            default: ;
          endcase
        end
        // read one length per entry, then tally
        SCount: state_q <= SCountW;
        SCountW: begin
          if (lr_data > 8'(L)) too_long_q <= 1'b1;
          else if (lr_data != 8'd0) begin
            cnt_q[lslot] <= cnt_q[lslot] + 9'd1;
            if (lr_data[5:0] > longest_q) longest_q <= lr_data[5:0];
          end
          if (idx_q == 9'd255) begin
            state_q <= SFirst;
            len_q <= 6'd1;
            code_q <= '0;
            fidx_q <= '0;
            idx_q <= '0;
          end else begin
            idx_q <= idx_q + 9'd1;
            state_q <= SCount;
          end
        end
        // first code and index, one length a cycle
        SFirst: begin
          fc_q[len_slot] <= (code_q + 32'(cnt_prev)) << 1;
          code_q <= (code_q + 32'(cnt_prev)) << 1;
          fi_q[len_slot] <= fidx_q;
          slot_q[len_slot] <= fidx_q;
          fidx_q <= fidx_q + cnt_q[len_slot];
          if (len_q == 6'(L)) state_q <= SPlace;
          else len_q <= len_q + 6'd1;
        end
        SPlace: state_q <= SPlaceW;
        SPlaceW: begin
          if (ok_len) slot_q[lslot] <= slot_q[lslot] + 9'd1;
          if (idx_q == 9'd255) begin
            state_q <= SIdle;
            if (too_long_q) begin
              run_q <= RunError;
              res_sym_q <= '0; res_st_q <= chd_pkg::StTooLong;
              res_done_q <= 1'b0; res_last_q <= 1'b1;
              m_axis_tvalid <= 1'b1;
            end else if (rem_q != 64'd0) begin
              run_q <= RunActive;
            end else begin
              run_q <= RunIdle;
            end
          end else begin
            idx_q <= idx_q + 9'd1;
            state_q <= SPlace;
          end
        end
        // one compressed bit per step
        SBit: begin
          if (held_q && (nlen > longest_q || hit)) begin
            // another result follows, so the waiting symbol is not the last
            held_q <= 1'b0;
            res_last_q <= 1'b0;
            m_axis_tvalid <= 1'b1;
            state_q <= SOut;
          end else if (nlen > longest_q || nlen > 6'(L)) begin
            run_q <= RunError;
            res_sym_q <= '0; res_st_q <= chd_pkg::StNoCode;
            res_done_q <= 1'b0; res_last_q <= 1'b1;
            m_axis_tvalid <= 1'b1;
            state_q <= SIdle;
          end else if (hit) begin
            rem_q <= rem_q - 64'd1;
            pc_q <= '0; plen_q <= '0;
            byte_q <= {byte_q[6:0], 1'b0};
            bits_q <= bits_q - 4'd1;
            state_q <= SBitW;
          end else begin
            pc_q <= npc; plen_q <= nlen;
            byte_q <= {byte_q[6:0], 1'b0};
            bits_q <= bits_q - 4'd1;
            if (bits_q == 4'd1) begin
              state_q <= SIdle;
              if (held_q) begin
                held_q <= 1'b0;
                res_last_q <= 1'b1;
                m_axis_tvalid <= 1'b1;
              end
            end
          end
        end
        // symbol read data arrives in the cycle after the hit step
        SBitW: begin
          res_sym_q <= sr_data;
          res_st_q <= chd_pkg::StSymbol;
          res_done_q <= (rem_q == 64'd0);
          if (rem_q == 64'd0) run_q <= RunIdle;
          if ((rem_q == 64'd0) || (bits_q == 4'd0)) begin
            res_last_q <= 1'b1;
            m_axis_tvalid <= 1'b1;
            state_q <= SOut;
          end else begin
            held_q <= 1'b1;
            state_q <= SBit;
          end
        end
        SOut: if (!m_axis_tvalid || m_axis_tready) begin
          if (res_last_q) state_q <= SIdle;
          else state_q <= SBit;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // output packing
  assign m_axis_tdata = {7'd0, res_done_q, res_sym_q};
  assign m_axis_tuser = res_st_q;
  assign m_axis_tlast = res_last_q;
endmodule
`default_nettype wire
